>>> src/spi_master_byte_shifter_core_macros.svh
// Assertion macros used by the SPI byte shifter RTL
`ifndef SPI_MASTER_BYTE_SHIFTER_CORE_MACROS_SVH
`define SPI_MASTER_BYTE_SHIFTER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SMBS_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("smbs assertion failed");

// Next-cycle implication, checked out of reset
`define SMBS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("smbs assertion failed");

`endif

>>> src/smbs_pkg.sv
// Types and constants for the SPI master byte shifter
package smbs_pkg;

    localparam int DATA_BITS = 8;
    localparam int CNT_W     = $clog2(DATA_BITS + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SPI_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_WIRE  = 2'd2;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam logic [1:0] PH_SETUP  = 2'd0;
    localparam logic [1:0] PH_ACTIVE = 2'd1;
    localparam logic [1:0] PH_HOLD   = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       miso;
    } in_word_t;

    typedef struct packed {
        logic       sck;
        logic       mosi;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
    } out_word_t;

endpackage

>>> src/spi_master_byte_shifter_core.sv
// SPI master byte shifter: bit sequencer with registered result word
// The result word of an accepted word sits in the output register from the next cycle on.
// Throughput: one word per cycle while the input is not stalled; the sequencer state advances once per accepted word.
// The input stalls only while the output register holds a word that is itself stalled.
// rst_n clears all sequencer state and config to mode 0, half_period 1, three_wire 0.
// Reset leaves SCK at the mode 0 idle level (low) and the output register empty.
`include "spi_master_byte_shifter_core_macros.svh"

module spi_master_byte_shifter_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  smbs_pkg::in_word_t             in_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output smbs_pkg::out_word_t            out_word,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [smbs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import smbs_pkg::*;

    logic [1:0]           spi_mode_reg;
    logic [7:0]           half_period_reg;
    logic                 three_wire_reg;

    logic [DATA_BITS-1:0] tx_shift_reg, tx_shift_next;
    logic [DATA_BITS-1:0] rx_shift_reg, rx_shift_next;
    logic [CNT_W-1:0]     bits_left_reg, bits_left_next;
    logic [1:0]           bit_phase_reg, bit_phase_next;
    logic [7:0]           delay_count_reg, delay_count_next;
    logic                 sck_level_reg, sck_level_next;
    logic                 mosi_level_reg, mosi_level_next;
    logic                 active_reg, active_next;

    logic                 out_valid_reg;
    out_word_t            out_word_reg, out_word_next;

    logic                 in_accept;
    logic                 cfg_write;
    logic                 idle_lvl;
    logic                 cpha;
    logic [7:0]           unit_ticks;
    logic [DATA_BITS-1:0] sample_val;
    logic [CNT_W-1:0]     bits_dec;
    logic                 done;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;

    assign idle_lvl   = spi_mode_reg[1];
    assign cpha       = spi_mode_reg[0];
    assign unit_ticks = (half_period_reg == 8'd0) ? 8'd1 : half_period_reg;
    assign sample_val = three_wire_reg ? rx_shift_reg
                                       : DATA_BITS'({rx_shift_reg, in_word.miso});
    assign bits_dec   = (bits_left_reg != '0) ? bits_left_reg - 1'b1 : '0;

    always_comb
    begin
        tx_shift_next    = tx_shift_reg;
        rx_shift_next    = rx_shift_reg;
        bits_left_next   = bits_left_reg;
        bit_phase_next   = bit_phase_reg;
        delay_count_next = delay_count_reg;
        sck_level_next   = sck_level_reg;
        mosi_level_next  = mosi_level_reg;
        active_next      = active_reg;
        done             = 1'b0;

        if (in_accept)
        begin
            if (in_word.kind == KIND_START)
            begin
                if (!active_reg)
                begin
                    // load and run the setup step of the first bit at once
                    rx_shift_next    = '0;
                    bits_left_next   = CNT_W'(DATA_BITS);
                    active_next      = 1'b1;
                    mosi_level_next  = in_word.tx_byte[DATA_BITS-1];
                    tx_shift_next    = DATA_BITS'(in_word.tx_byte) << 1;
                    sck_level_next   = cpha ? ~idle_lvl : idle_lvl;
                    bit_phase_next   = PH_SETUP;
                    delay_count_next = unit_ticks;
                end
            end
            else if (active_reg)
            begin
                if (delay_count_reg > 8'd1)
                begin
                    delay_count_next = delay_count_reg - 8'd1;
                end
                else
                begin
                    case (bit_phase_reg)
                        PH_SETUP:
                        begin
                            if (cpha)
                            begin
                                sck_level_next = idle_lvl;
                                rx_shift_next  = sample_val;
                                bit_phase_next = PH_ACTIVE;
                            end
                            else
                            begin
                                sck_level_next = ~idle_lvl;
                                bit_phase_next = PH_ACTIVE;
                            end
                            delay_count_next = unit_ticks;
                        end
                        PH_ACTIVE:
                        begin
                            if (!cpha)
                            begin
                                rx_shift_next    = sample_val;
                                sck_level_next   = idle_lvl;
                                bit_phase_next   = PH_HOLD;
                                delay_count_next = unit_ticks;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // close the bit: end of hold step, or active step in phase-1 modes
                    if ((bit_phase_reg != PH_SETUP) &&
                        !(bit_phase_reg == PH_ACTIVE && !cpha))
                    begin
                        bits_left_next = bits_dec;
                        if (bits_dec == '0)
                        begin
                            active_next      = 1'b0;
                            bit_phase_next   = PH_SETUP;
                            delay_count_next = 8'd0;
                            sck_level_next   = idle_lvl;
                            done             = 1'b1;
                        end
                        else
                        begin
                            mosi_level_next  = tx_shift_reg[DATA_BITS-1];
                            tx_shift_next    = tx_shift_reg << 1;
                            sck_level_next   = cpha ? ~idle_lvl : sck_level_reg;
                            bit_phase_next   = PH_SETUP;
                            delay_count_next = unit_ticks;
                        end
                    end
                end
            end
            else
            begin
                sck_level_next = idle_lvl;
            end
        end

        // a mode write while idle moves SCK to the new idle level
        if (cfg_write && cfg_index == CFG_SPI_MODE && !active_reg)
        begin
            sck_level_next = cfg_data[1];
        end
    end

    always_comb
    begin
        out_word_next.sck      = sck_level_next;
        out_word_next.mosi     = mosi_level_next;
        out_word_next.busy_res = active_next;
        out_word_next.done_res = done;
        out_word_next.rx_byte  = done ? 8'(rx_shift_next) : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spi_mode_reg    <= 2'd0;
            half_period_reg <= 8'd1;
            three_wire_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SPI_MODE:    spi_mode_reg    <= cfg_data[1:0];
                CFG_HALF_PERIOD: half_period_reg <= cfg_data;
                CFG_THREE_WIRE:  three_wire_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_shift_reg    <= '0;
            rx_shift_reg    <= '0;
            bits_left_reg   <= '0;
            bit_phase_reg   <= PH_SETUP;
            delay_count_reg <= 8'd0;
            sck_level_reg   <= 1'b0;
            mosi_level_reg  <= 1'b0;
            active_reg      <= 1'b0;
        end
        else
        begin
            tx_shift_reg    <= tx_shift_next;
            rx_shift_reg    <= rx_shift_next;
            bits_left_reg   <= bits_left_next;
            bit_phase_reg   <= bit_phase_next;
            delay_count_reg <= delay_count_next;
            sck_level_reg   <= sck_level_next;
            mosi_level_reg  <= mosi_level_next;
            active_reg      <= active_next;
        end
    end

    // hold the result word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    `SMBS_ASSERT_NOW(a_active_bits, 1'b1, active_reg == (bits_left_reg != '0))
    `SMBS_ASSERT_NOW(a_idle_sck, !active_reg, sck_level_reg == spi_mode_reg[1])
    `SMBS_ASSERT_NEXT(a_start_busy, in_accept && in_word.kind == KIND_START && !active_reg, active_reg)
    `SMBS_ASSERT_NOW(a_done_idle, out_valid_reg && out_word_reg.done_res, !out_word_reg.busy_res)

endmodule

>>> bench/tb_spi_master_byte_shifter_core.sv
// Self-checking testbench for the SPI master byte shifter core
module tb_spi_master_byte_shifter_core;

    import smbs_pkg::*;

    localparam int                   CYCLE_LIMIT = 200000;
    localparam int                   RAND_ITEMS  = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_word_t             in_word   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_word_t            out_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    // shadow copy of the shifter configuration and sequencer state
    logic [1:0]       cur_mode = 2'd0;
    logic [7:0]       cur_half = 8'd1;
    logic             cur_3w   = 1'b0;
    logic [7:0]       tx_sr    = '0;
    logic [7:0]       rx_sr    = '0;
    logic [CNT_W-1:0] bits_rem = '0;
    logic [1:0]       phase    = PH_SETUP;
    logic [7:0]       dly      = '0;
    logic             sck_q    = 1'b0;
    logic             mosi_q   = 1'b0;
    logic             busy_q   = 1'b0;

    in_word_t  word_backlog[$];
    out_word_t pins_expected[$];
    out_word_t want_w;
    int        fed_total   = 0;
    int        taken_total = 0;
    int        fail_cnt    = 0;
    int        cycle_cnt   = 0;
    int        send_gap    = 0;
    int        recv_hold   = 0;
    logic      calm        = 1'b0;

    spi_master_byte_shifter_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [7:0] unit_len();
        return (cur_half == 8'd0) ? 8'd1 : cur_half;
    endfunction

    // drive the next MOSI bit; CPHA modes also move SCK off idle here
    function automatic void launch_bit();
        mosi_q = tx_sr[7];
        tx_sr  = tx_sr << 1;
        if (cur_mode[0])
            sck_q = ~cur_mode[1];
        phase = PH_SETUP;
        dly   = unit_len();
    endfunction

    function automatic logic close_bit();
        if (bits_rem > 0)
            bits_rem--;
        if (bits_rem == 0)
        begin
            busy_q = 1'b0;
            phase  = PH_SETUP;
            dly    = '0;
            sck_q  = cur_mode[1];
            return 1'b1;
        end
        launch_bit();
        return 1'b0;
    endfunction

    function automatic out_word_t spi_step(in_word_t w);
        out_word_t r;
        logic      fin;
        fin = 1'b0;
        if (w.kind == KIND_START)
        begin
            if (!busy_q)
            begin
                tx_sr    = w.tx_byte;
                rx_sr    = '0;
                bits_rem = CNT_W'(DATA_BITS);
                busy_q   = 1'b1;
                sck_q    = cur_mode[1];
                launch_bit();
            end
        end
        else if (busy_q)
        begin
            if (dly > 8'd1)
                dly--;
            else if (!cur_mode[0])
            begin
                case (phase)
                    PH_SETUP:
                    begin
                        sck_q = ~cur_mode[1];
                        phase = PH_ACTIVE;
                        dly   = unit_len();
                    end
                    PH_ACTIVE:
                    begin
                        if (!cur_3w)
                            rx_sr = {rx_sr[6:0], w.miso};
                        sck_q = cur_mode[1];
                        phase = PH_HOLD;
                        dly   = unit_len();
                    end
                    default:
                        fin = close_bit();
                endcase
            end
            else if (phase == PH_SETUP)
            begin
                sck_q = cur_mode[1];
                if (!cur_3w)
                    rx_sr = {rx_sr[6:0], w.miso};
                phase = PH_ACTIVE;
                dly   = unit_len();
            end
            else
                fin = close_bit();   // a leftover third step also ends the bit
        end
        else
            sck_q = cur_mode[1];
        r.sck      = sck_q;
        r.mosi     = mosi_q;
        r.busy_res = busy_q;
        r.done_res = fin;
        r.rx_byte  = fin ? rx_sr : 8'd0;
        return r;
    endfunction

    function automatic void check_pin(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    task automatic feed(input logic k, input logic [7:0] b, input logic m);
        in_word_t w;
        w.kind    = k;
        w.tx_byte = b;
        w.miso    = m;
        word_backlog.push_back(w);
        fed_total++;
    endtask

    // leaves cfg_valid high so that writes can follow back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SPI_MODE:
            begin
                cur_mode = val[1:0];
                if (!busy_q)
                    sck_q = val[1];
            end
            CFG_HALF_PERIOD: cur_half = val;
            CFG_THREE_WIRE:  cur_3w = val[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [1:0] m, input logic [7:0] h, input logic t);
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        write_reg(CFG_SPI_MODE, {junk[7:2], m});
        write_reg(CFG_HALF_PERIOD, h);
        write_reg(CFG_THREE_WIRE, {junk[6:0], t});
        cfg_valid <= 1'b0;
    endtask

    // hold until every queued word went in and every result came back
    task automatic drain();
        do @(posedge clk); while (taken_total != fed_total || pins_expected.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pins_expected.push_back(spi_step(in_word));
                taken_total++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (word_backlog.size() > 0)
                begin
                    in_word  <= word_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 4);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pins_expected.size() == 0)
                begin
                    $error("result word %h with nothing expected", out_word);
                    fail_cnt++;
                end
                else
                begin
                    want_w = pins_expected.pop_front();
                    check_pin("sck", 8'(want_w.sck), 8'(out_word.sck));
                    check_pin("mosi", 8'(want_w.mosi), 8'(out_word.mosi));
                    check_pin("busy_res", 8'(want_w.busy_res), 8'(out_word.busy_res));
                    check_pin("done_res", 8'(want_w.done_res), 8'(out_word.done_res));
                    check_pin("rx_byte", want_w.rx_byte, out_word.rx_byte);
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                recv_hold = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int         k;
        int         ph;
        int         need;
        int         xfers;
        int         rand_items;
        logic [1:0] mode_v;
        logic [7:0] half_v;
        logic       tw_v;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // write to an index with no register behind it, then a zero delay unit
        write_reg(CFG_UNUSED, 8'hFF);
        program_regs(2'd1, 8'd0, 1'b0);
        feed(KIND_TICK, 8'h3C, 1'b1);
        feed(KIND_START, 8'hFF, 1'b0);
        feed(KIND_START, 8'h00, 1'b1);   // dropped: transfer under way
        for (k = 0; k < 16; k++)
            feed(KIND_TICK, k[0] ? 8'hFF : 8'h00, k[0]);
        feed(KIND_TICK, 8'h00, 1'b0);
        drain();

        // SCK jumps high on the idle write; then switch mode while in the hold step
        program_regs(2'd2, 8'd1, 1'b1);
        feed(KIND_START, 8'h00, 1'b1);
        feed(KIND_TICK, 8'hA5, 1'b1);
        feed(KIND_TICK, 8'h5A, 1'b0);
        drain();
        write_reg(CFG_SPI_MODE, 8'hFF);
        cfg_valid <= 1'b0;
        repeat (4) feed(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        drain();

        // longest delay unit, mid-transfer
        write_reg(CFG_HALF_PERIOD, 8'hFF);
        cfg_valid <= 1'b0;
        repeat (300) feed(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        rand_items = 0;
        ph         = 0;
        while (rand_items < RAND_ITEMS)
        begin
            drain();
            calm   = (rand_items > RAND_ITEMS - 130);
            mode_v = (ph < 4) ? ph[1:0] : 2'($urandom_range(0, 3));
            half_v = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 12))
                                                 : 8'($urandom_range(1, 3));
            tw_v   = 1'($urandom_range(0, 1));
            program_regs(mode_v, half_v, tw_v);
            xfers = $urandom_range(1, 3);
            repeat (xfers)
            begin
                need = 8 * (mode_v[0] ? 2 : 3) * half_v;
                if ($urandom_range(0, 9) == 0)
                    need = $urandom_range(1, need);   // cut short
                else
                    need += $urandom_range(0, 3);
                feed(KIND_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                rand_items++;
                for (k = 0; k < need; k++)
                begin
                    if ($urandom_range(0, 29) == 0)
                        feed(KIND_START, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                    feed(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    rand_items++;
                end
            end
            ph++;
        end

        drain();
        repeat (5) @(posedge clk);
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/smbs_pkg.sv
src/spi_master_byte_shifter_core.sv
bench/tb_spi_master_byte_shifter_core.sv
